// ===== rtl/vbc_pkg.sv =====
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types, register indexes and constants of the viewpoint box cull block.
// ----------------------------------------------------------------------------
package vbc_pkg;

	localparam int IDX_W = 16;
	localparam int CFG_IDX_W = 8;
	localparam int IN_DATA_W = 160;
	localparam int OUT_DATA_W = 152;

	localparam logic ACT_ANCHOR = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_STANDOFF = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_X = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_Y = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_Z = 8'd3;

	localparam logic [20:0] STANDOFF_RST = 21'd65536;
	localparam logic [30:0] EXT_X_RST = 31'd131072;
	localparam logic [30:0] EXT_Y_RST = 31'd98304;
	localparam logic [30:0] EXT_Z_RST = 31'd98304;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [23:0] HALF_PI_20 = 24'sd1647099;

	typedef struct packed {
		logic action;
		logic [IDX_W-1:0] idx;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] idx;
		logic hit;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} result_t;

	typedef struct packed {
		logic [20:0] standoff;
		logic [30:0] ext_x;
		logic [30:0] ext_y;
		logic [30:0] ext_z;
	} cfg_t;

	// arctangent of 2^-i in units of 2^-20 rad
	function automatic logic [19:0] atan_lut(input logic [4:0] i);
		logic [19:0] r;
		case (i)
			5'd0: r = 20'd823550;
			5'd1: r = 20'd486170;
			5'd2: r = 20'd256879;
			5'd3: r = 20'd130396;
			5'd4: r = 20'd65451;
			5'd5: r = 20'd32757;
			5'd6: r = 20'd16383;
			5'd7: r = 20'd8192;
			5'd8: r = 20'd4096;
			5'd9: r = 20'd2048;
			5'd10: r = 20'd1024;
			5'd11: r = 20'd512;
			5'd12: r = 20'd256;
			5'd13: r = 20'd128;
			5'd14: r = 20'd64;
			5'd15: r = 20'd32;
			5'd16: r = 20'd16;
			5'd17: r = 20'd8;
			5'd18: r = 20'd4;
			5'd19: r = 20'd2;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/vbc_front.sv =====
// ----------------------------------------------------------------------------
// vbc_front
// Input side: takes requests, splits them into item fields, queues two deep.
// ----------------------------------------------------------------------------
module vbc_front import vbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	output logic                  head_valid,
	input  logic                  head_ready,
	output item_t                 head
);

	item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;
	item_t in_item;

	always_comb begin
		in_item.action = s_tuser;
		in_item.idx = s_tdata[15:0];
		in_item.px = s_tdata[47:16];
		in_item.py = s_tdata[79:48];
		in_item.pz = s_tdata[111:80];
		in_item.nx = s_tdata[127:112];
		in_item.ny = s_tdata[143:128];
		in_item.nz = s_tdata[159:144];
	end

	assign s_tready = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = slot_q[rd_ptr_q];
	assign push = s_tvalid && s_tready;
	assign pop = head_valid && head_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/vbc_back.sv =====
// ----------------------------------------------------------------------------
// vbc_back
// Execution side: anchor solve (sqrt, divide, cordic) and box test, one item
// at a time, with a registered result stage.
// ----------------------------------------------------------------------------
module vbc_back import vbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    head_valid,
	output logic    head_ready,
	input  item_t   head,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_TMUL   = 20'h00002,
		S_TACC   = 20'h00004,
		S_ASQ    = 20'h00008,
		S_AL     = 20'h00010,
		S_SQRT   = 20'h00020,
		S_SQEND  = 20'h00040,
		S_DIVLD  = 20'h00080,
		S_DIV    = 20'h00100,
		S_DIVEND = 20'h00200,
		S_POSM   = 20'h00400,
		S_POS    = 20'h00800,
		S_HSQ    = 20'h01000,
		S_HL     = 20'h02000,
		S_ROTM   = 20'h04000,
		S_ROT    = 20'h08000,
		S_CPRE   = 20'h10000,
		S_CORD   = 20'h20000,
		S_CEND   = 20'h40000,
		S_DONE   = 20'h80000
	} state_t;

	function automatic logic signed [50:0] rnd14(input logic signed [50:0] v);
		logic signed [50:0] r;
		if (v >= 0) r = (v + 51'sd8192) >>> 14;
		else r = -((-v + 51'sd8192) >>> 14);
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd2147483647) r = 32'sh7fffffff;
		else if (v < -52'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [15:0] abs16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

	state_t state_q;
	item_t item_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] rot_q [9];
	logic signed [32:0] diff_q [3];
	logic signed [50:0] prod_s1 [3];
	logic signed [16:0] ma [3];
	logic signed [33:0] mb [3];
	logic [1:0] col_q;
	logic ok_q;
	logic signed [15:0] d_q [3];
	logic signed [15:0] s_q;
	logic signed [15:0] c_q;
	logic [31:0] nrm_q;
	logic [31:0] hh_q;
	logic [5:0] step_q;
	logic [63:0] sq_v_q;
	logic [63:0] sq_r_q;
	logic sq_job_q;
	logic [32:0] dv_rem_q;
	logic [47:0] dv_num_q;
	logic [31:0] dv_den_q;
	logic dv_neg_q;
	logic [2:0] dv_job_q;
	logic signed [26:0] cx_q;
	logic signed [26:0] cy_q;
	logic signed [23:0] cz_q;
	logic cj_q;
	logic czero_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] yaw_q;
	result_t res_q;
	logic res_valid_q;

	// comb helpers
	logic signed [50:0] tsum;
	logic [50:0] tmag;
	logic [30:0] ext_sel;
	logic [31:0] lsum;
	logic [29:0] hsum;
	logic [5:0] sq_sh;
	logic [63:0] sq_b;
	logic [63:0] sq_t;
	logic [32:0] dv_rn;
	logic [15:0] dv_mag;
	logic [47:0] dv_start;
	logic [31:0] dv_den_start;
	logic dv_neg_start;
	logic [47:0] dv_qc;
	logic signed [15:0] dv_val;
	logic signed [31:0] pos_new [3];
	logic signed [50:0] rnd_p0;
	logic signed [50:0] rnd_p1;
	logic signed [26:0] cxs;
	logic signed [26:0] cys;
	logic signed [23:0] cat;
	logic signed [23:0] zr;
	logic signed [15:0] ang;
	logic out_free;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ma[k] = '0;
			mb[k] = '0;
		end
		case (state_q)
			S_TMUL: begin
				for (int k = 0; k < 3; k++) begin
					mb[k] = 34'(diff_q[k]);
				end
				case (col_q)
					2'd0: begin
						ma[0] = 17'(rot_q[0]); ma[1] = 17'(rot_q[3]); ma[2] = 17'(rot_q[6]);
					end
					2'd1: begin
						ma[0] = 17'(rot_q[1]); ma[1] = 17'(rot_q[4]); ma[2] = 17'(rot_q[7]);
					end
					default: begin
						ma[0] = 17'(rot_q[2]); ma[1] = 17'(rot_q[5]); ma[2] = 17'(rot_q[8]);
					end
				endcase
			end
			S_ASQ: begin
				ma[0] = 17'($signed(item_q.nx)); mb[0] = 34'($signed(item_q.nx));
				ma[1] = 17'($signed(item_q.ny)); mb[1] = 34'($signed(item_q.ny));
				ma[2] = 17'($signed(item_q.nz)); mb[2] = 34'($signed(item_q.nz));
			end
			S_POSM: begin
				for (int k = 0; k < 3; k++) begin
					ma[k] = 17'(d_q[k]);
					mb[k] = $signed({13'd0, cfg.standoff});
				end
			end
			S_HSQ: begin
				ma[0] = 17'(d_q[0]); mb[0] = 34'(d_q[0]);
				ma[2] = 17'(d_q[2]); mb[2] = 34'(d_q[2]);
			end
			S_ROTM: begin
				ma[0] = 17'(s_q); mb[0] = 34'(d_q[1]);
				ma[1] = 17'(c_q); mb[1] = 34'(d_q[1]);
			end
			default: begin
				ma[0] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s1[k] <= ma[k] * mb[k];
		end
	end

	always_comb begin
		tsum = prod_s1[0] + prod_s1[1] + prod_s1[2];
		tmag = tsum[50] ? 51'(-tsum) : 51'(tsum);
		case (col_q)
			2'd0: ext_sel = cfg.ext_x;
			2'd1: ext_sel = cfg.ext_y;
			default: ext_sel = cfg.ext_z;
		endcase
		lsum = prod_s1[0][31:0] + prod_s1[1][31:0] + prod_s1[2][31:0];
		hsum = prod_s1[0][29:0] + prod_s1[2][29:0];

		sq_sh = 6'd62 - {step_q[4:0], 1'b0};
		sq_b = 64'd1 << sq_sh;
		sq_t = sq_r_q + sq_b;

		dv_rn = {dv_rem_q[31:0], dv_num_q[47]};

		case (dv_job_q)
			3'd0: begin dv_mag = abs16(item_q.nx); dv_neg_start = item_q.nx[15]; end
			3'd1: begin dv_mag = abs16(item_q.ny); dv_neg_start = item_q.ny[15]; end
			3'd2: begin dv_mag = abs16(item_q.nz); dv_neg_start = item_q.nz[15]; end
			3'd3: begin dv_mag = abs16(d_q[0]); dv_neg_start = d_q[0][15]; end
			default: begin dv_mag = abs16(d_q[2]); dv_neg_start = d_q[2][15]; end
		endcase
		if (dv_job_q < 3'd3) begin
			dv_den_start = nrm_q;
			dv_start = {4'd0, dv_mag, 28'd0} + {17'd0, nrm_q[31:1]};
		end else begin
			dv_den_start = hh_q;
			dv_start = {10'd0, dv_mag, 22'd0} + {17'd0, hh_q[31:1]};
		end
		dv_qc = (dv_num_q > 48'd16384) ? 48'd16384 : dv_num_q;
		dv_val = dv_neg_q ? -$signed(dv_qc[15:0]) : $signed(dv_qc[15:0]);

		for (int k = 0; k < 3; k++) begin
			pos_new[k] = '0;
		end
		pos_new[0] = sat32(52'($signed(item_q.px)) - 52'(rnd14(prod_s1[0])));
		pos_new[1] = sat32(52'($signed(item_q.py)) - 52'(rnd14(prod_s1[1])));
		pos_new[2] = sat32(52'($signed(item_q.pz)) - 52'(rnd14(prod_s1[2])));
		rnd_p0 = rnd14(prod_s1[0]);
		rnd_p1 = rnd14(prod_s1[1]);

		cxs = cx_q >>> step_q[4:0];
		cys = cy_q >>> step_q[4:0];
		cat = $signed({4'd0, atan_lut(step_q[4:0])});

		if (cz_q >= 0) zr = (cz_q + 24'sd64) >>> 7;
		else zr = -((-cz_q + 24'sd64) >>> 7);
		if (czero_q) ang = '0;
		else if (zr > 24'sd32767) ang = 16'sh7fff;
		else if (zr < -24'sd32768) ang = 16'sh8000;
		else ang = zr[15:0];
	end

	assign out_free = !res_valid_q || res_ready;
	assign head_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= '0;
			end
			for (int k = 0; k < 9; k++) begin
				rot_q[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q14 : '0;
			end
			col_q <= '0;
			step_q <= '0;
			sq_job_q <= 1'b0;
			dv_job_q <= '0;
			cj_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						item_q <= head;
						diff_q[0] <= 33'($signed(head.px)) - 33'(pos_q[0]);
						diff_q[1] <= 33'($signed(head.py)) - 33'(pos_q[1]);
						diff_q[2] <= 33'($signed(head.pz)) - 33'(pos_q[2]);
						col_q <= 2'd0;
						ok_q <= 1'b1;
						state_q <= (head.action == ACT_TEST) ? S_TMUL : S_ASQ;
					end
				end
				S_TMUL: state_q <= S_TACC;
				S_TACC: begin
					if (tmag > {6'd0, ext_sel, 14'd0}) ok_q <= 1'b0;
					if (col_q == 2'd2) state_q <= S_DONE;
					else begin
						col_q <= col_q + 2'd1;
						state_q <= S_TMUL;
					end
				end
				S_ASQ: state_q <= S_AL;
				S_AL: begin
					pitch_q <= '0;
					yaw_q <= '0;
					if (lsum == 32'd0) begin
						pos_q[0] <= item_q.px;
						pos_q[1] <= item_q.py;
						pos_q[2] <= item_q.pz;
						for (int k = 0; k < 9; k++) begin
							rot_q[k] <= (k == 0 || k == 4 || k == 8) ? ONE_Q14 : '0;
						end
						state_q <= S_DONE;
					end else begin
						sq_v_q <= {4'd0, lsum, 28'd0};
						sq_r_q <= '0;
						sq_job_q <= 1'b0;
						step_q <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_v_q >= sq_t) begin
						sq_v_q <= sq_v_q - sq_t;
						sq_r_q <= (sq_r_q >> 1) + sq_b;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					if (step_q == 6'd31) state_q <= S_SQEND;
					else step_q <= step_q + 6'd1;
				end
				S_SQEND: begin
					if (!sq_job_q) begin
						nrm_q <= sq_r_q[31:0];
						dv_job_q <= 3'd0;
						state_q <= S_DIVLD;
					end else begin
						hh_q <= sq_r_q[31:0];
						if (sq_r_q == 64'd0) begin
							s_q <= '0;
							c_q <= ONE_Q14;
							state_q <= S_ROTM;
						end else begin
							dv_job_q <= 3'd3;
							state_q <= S_DIVLD;
						end
					end
				end
				S_DIVLD: begin
					dv_num_q <= dv_start;
					dv_den_q <= dv_den_start;
					dv_neg_q <= dv_neg_start;
					dv_rem_q <= '0;
					step_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dv_rn >= {1'b0, dv_den_q}) begin
						dv_rem_q <= dv_rn - {1'b0, dv_den_q};
						dv_num_q <= {dv_num_q[46:0], 1'b1};
					end else begin
						dv_rem_q <= dv_rn;
						dv_num_q <= {dv_num_q[46:0], 1'b0};
					end
					if (step_q == 6'd47) state_q <= S_DIVEND;
					else step_q <= step_q + 6'd1;
				end
				S_DIVEND: begin
					case (dv_job_q)
						3'd0: begin d_q[0] <= dv_val; dv_job_q <= 3'd1; state_q <= S_DIVLD; end
						3'd1: begin d_q[1] <= dv_val; dv_job_q <= 3'd2; state_q <= S_DIVLD; end
						3'd2: begin d_q[2] <= dv_val; state_q <= S_POSM; end
						3'd3: begin s_q <= dv_val; dv_job_q <= 3'd4; state_q <= S_DIVLD; end
						default: begin c_q <= dv_val; state_q <= S_ROTM; end
					endcase
				end
				S_POSM: state_q <= S_POS;
				S_POS: begin
					for (int k = 0; k < 3; k++) begin
						pos_q[k] <= pos_new[k];
					end
					state_q <= S_HSQ;
				end
				S_HSQ: state_q <= S_HL;
				S_HL: begin
					sq_v_q <= {18'd0, hsum, 16'd0};
					sq_r_q <= '0;
					sq_job_q <= 1'b1;
					step_q <= '0;
					state_q <= S_SQRT;
				end
				S_ROTM: state_q <= S_ROT;
				S_ROT: begin
					rot_q[0] <= c_q;
					rot_q[1] <= -rnd_p0[15:0];
					rot_q[2] <= d_q[0];
					rot_q[3] <= '0;
					rot_q[4] <= 16'(hh_q[31:8] + {23'd0, hh_q[7]});
					rot_q[5] <= d_q[1];
					rot_q[6] <= -s_q;
					rot_q[7] <= -rnd_p1[15:0];
					rot_q[8] <= d_q[2];
					cx_q <= $signed({1'b0, hh_q[25:0]});
					cy_q <= 27'($signed({d_q[1], 8'd0}));
					cz_q <= '0;
					cj_q <= 1'b0;
					state_q <= S_CPRE;
				end
				S_CPRE: begin
					czero_q <= (cx_q == 0) && (cy_q == 0);
					if (cx_q < 0) begin
						if (cy_q >= 0) begin
							cx_q <= cy_q;
							cy_q <= -cx_q;
							cz_q <= HALF_PI_20;
						end else begin
							cx_q <= -cy_q;
							cy_q <= cx_q;
							cz_q <= -HALF_PI_20;
						end
					end
					step_q <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (cy_q >= 0) begin
						cx_q <= cx_q + cys;
						cy_q <= cy_q - cxs;
						cz_q <= cz_q + cat;
					end else begin
						cx_q <= cx_q - cys;
						cy_q <= cy_q + cxs;
						cz_q <= cz_q - cat;
					end
					if (step_q == 6'd19) state_q <= S_CEND;
					else step_q <= step_q + 6'd1;
				end
				S_CEND: begin
					if (!cj_q) begin
						pitch_q <= -ang;
						cj_q <= 1'b1;
						cx_q <= 27'($signed({d_q[2], 8'd0}));
						cy_q <= 27'($signed({d_q[0], 8'd0}));
						cz_q <= '0;
						state_q <= S_CPRE;
					end else begin
						yaw_q <= ang;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_q.kind <= item_q.action;
						res_q.idx <= item_q.idx;
						if (item_q.action == ACT_TEST) begin
							res_q.hit <= ok_q;
							res_q.vx <= '0;
							res_q.vy <= '0;
							res_q.vz <= '0;
							res_q.pitch <= '0;
							res_q.yaw <= '0;
						end else begin
							res_q.hit <= 1'b0;
							res_q.vx <= pos_q[0];
							res_q.vy <= pos_q[1];
							res_q.vz <= pos_q[2];
							res_q.pitch <= pitch_q;
							res_q.yaw <= yaw_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/viewpoint_box_cull.sv =====
// ----------------------------------------------------------------------------
// viewpoint_box_cull
// Places a viewpoint off a surface point and culls points against its box.
// ----------------------------------------------------------------------------
// Input requests arrive on s_tvalid/s_tready; s_tuser is the action (0 anchor,
// 1 test). Results leave on m_tvalid/m_tready with the kind in m_tuser.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data (cfg_ready
// is always high); write them only while the block is idle, not enforced here.
// A two-deep input queue keeps taking requests while the execution unit is
// busy or a result waits in the output register.
// Test request: three columns, each a state of three parallel multiplies and
// then a state of sum and compare, from queue head to result register.
// Anchor request: a bit-serial square root (run twice), five restoring
// divisions (three when the horizontal length is zero) and two 20-step CORDIC
// passes sharing one datapath; a zero normal skips the solve.
// Items are handled one at a time in order, one result per request.
// Reset clears the queue, sets the viewpoint to the origin with identity
// rotation and loads the register defaults.
// When m_tready is low the result holds, the execution unit finishes the next
// request and waits, and the queue fills and then drops s_tready.
// ----------------------------------------------------------------------------
module viewpoint_box_cull import vbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// idx, px, py, pz, nx, ny, nz
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// idx, hit, vx, vy, vz, pitch, yaw, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// result kind
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data
);

	cfg_t cfg_q;
	logic head_valid;
	logic head_ready;
	item_t head;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.standoff <= STANDOFF_RST;
			cfg_q.ext_x <= EXT_X_RST;
			cfg_q.ext_y <= EXT_Y_RST;
			cfg_q.ext_z <= EXT_Z_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STANDOFF: cfg_q.standoff <= cfg_data[20:0];
				REG_EXT_X: cfg_q.ext_x <= cfg_data[30:0];
				REG_EXT_Y: cfg_q.ext_y <= cfg_data[30:0];
				REG_EXT_Z: cfg_q.ext_z <= cfg_data[30:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	vbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head)
	);

	vbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {7'd0, res.yaw, res.pitch, res.vz, res.vy, res.vx, res.hit, res.idx};

	a_anchor_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_ANCHOR) |-> !m_tdata[16])
		else $error("anchor result flagged as hit");

	a_test_no_view: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_TEST) |-> (m_tdata[144:17] == '0))
		else $error("test result carries view fields");

	a_full_queue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> head_valid)
		else $error("input stalled with empty queue");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for viewpoint_box_cull: anchor and point-test requests
// are streamed with random gaps and back-pressure, a local fixed-point model
// predicts every result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
	import vbc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	viewpoint_box_cull u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// viewpoint model state
	longint standoff, ext[3];
	longint vpos[3], vrot[9];

	item_t pending_q[$];
	result_t expected_q[$];
	item_t cur_req;
	int n_acc = 0, n_sent = 0, n_res = 0, n_res_seen = 0;
	int s_gap = 0, m_wait = 0;
	bit s_quiet = 0, m_quiet = 0;
	int errors = 0, cycles = 0;
	int n_anchor = 0, n_test = 0, n_hit = 0;

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint shr_rnd(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint div_rnd(longint num, longint den);
		longint mag;
		if (den <= 0)
			return 0;
		mag = num < 0 ? -num : num;
		mag = (mag + den / 2) / den;
		return num < 0 ? -mag : mag;
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint cordic_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI_20;
			end else begin
				x = -y; y = t; z = -HALF_PI_20;
			end
		end
		for (int i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(atan_lut(i[4:0]));
			end else begin
				x = x - ys; y = y + xs; z -= longint'(atan_lut(i[4:0]));
			end
		end
		return clampl(shr_rnd(z, 7), -32768, 32767);
	endfunction

	function automatic result_t place_or_cull(item_t it);
		result_t r;
		longint q[3], n[3], d[3], dif[3];
		longint lsq, nrm, hl, s, c, h, t, mag;
		bit ok;
		r = '0;
		r.kind = it.action;
		r.idx = it.idx;
		q[0] = longint'($signed(it.px));
		q[1] = longint'($signed(it.py));
		q[2] = longint'($signed(it.pz));
		n[0] = longint'($signed(it.nx));
		n[1] = longint'($signed(it.ny));
		n[2] = longint'($signed(it.nz));
		if (it.action == ACT_ANCHOR) begin
			lsq = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
			vrot = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
			if (lsq == 0) begin
				vpos = q;
			end else begin
				nrm = isqrt(longint'(lsq) << 28);
				for (int i = 0; i < 3; i++) begin
					d[i] = clampl(div_rnd(n[i] * 268435456, nrm), -16384, 16384);
					vpos[i] = clampl(q[i] - shr_rnd(standoff * d[i], 14),
						-64'sd2147483648, 64'sd2147483647);
				end
				hl = isqrt((d[0] * d[0] + d[2] * d[2]) << 16);
				if (hl == 0) begin
					s = 0; c = 16384; h = 0;
				end else begin
					s = clampl(div_rnd(d[0] * 4194304, hl), -16384, 16384);
					c = clampl(div_rnd(d[2] * 4194304, hl), -16384, 16384);
					h = shr_rnd(hl, 8);
				end
				vrot = '{c, -shr_rnd(s * d[1], 14), d[0], 0, h, d[1], -s,
					-shr_rnd(c * d[1], 14), d[2]};
				r.pitch = 16'(-cordic_angle(d[1] * 256, hl));
				r.yaw = 16'(cordic_angle(d[0] * 256, d[2] * 256));
			end
			r.vx = 32'(vpos[0]);
			r.vy = 32'(vpos[1]);
			r.vz = 32'(vpos[2]);
		end else begin
			ok = 1;
			for (int i = 0; i < 3; i++)
				dif[i] = q[i] - vpos[i];
			for (int j = 0; j < 3; j++) begin
				t = 0;
				for (int i = 0; i < 3; i++)
					t += vrot[i * 3 + j] * dif[i];
				mag = t < 0 ? -t : t;
				if (mag > (ext[j] << 14))
					ok = 0;
			end
			r.hit = ok;
		end
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_tvalid && s_tready) begin
			expected_q.insert(expected_q.size(), place_or_cull(cur_req));
			n_acc <= n_acc + 1;
		end
	end

	always @(negedge clk) begin
		item_t nxt;
		if (arst_n && (n_sent == n_acc)) begin
			if (s_gap > 0) begin
				s_gap <= s_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				nxt = pending_q.pop_front();
				cur_req <= nxt;
				s_tuser <= nxt.action;
				s_tdata <= {nxt.nz, nxt.ny, nxt.nx, nxt.pz, nxt.py, nxt.px, nxt.idx};
				s_tvalid <= 1'b1;
				n_sent <= n_sent + 1;
				if ($urandom_range(0, 15) == 0)
					s_quiet = ~s_quiet;
				s_gap <= s_quiet ? 0 : $urandom_range(0, 4);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t exp_r, got;
		if (m_tvalid && m_tready) begin
			n_res <= n_res + 1;
			got = '0;
			got.kind = m_tuser;
			got.idx = m_tdata[15:0];
			got.hit = m_tdata[16];
			got.vx = m_tdata[48:17];
			got.vy = m_tdata[80:49];
			got.vz = m_tdata[112:81];
			got.pitch = m_tdata[128:113];
			got.yaw = m_tdata[144:129];
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, got %p", $time, got);
			end else begin
				exp_r = expected_q.pop_front();
				if (exp_r.kind == ACT_ANCHOR)
					n_anchor++;
				else begin
					n_test++;
					n_hit += exp_r.hit;
				end
				if (got.kind !== exp_r.kind) begin
					errors++;
					$display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got.kind);
				end
				if (got.idx !== exp_r.idx) begin
					errors++;
					$display("%0t: index exp %0d got %0d", $time, exp_r.idx, got.idx);
				end
				if (got.hit !== exp_r.hit) begin
					errors++;
					$display("%0t: hit exp %0d got %0d (idx %0d)", $time,
						exp_r.hit, got.hit, exp_r.idx);
				end
				if (got.vx !== exp_r.vx || got.vy !== exp_r.vy || got.vz !== exp_r.vz) begin
					errors++;
					$display("%0t: position exp %h %h %h got %h %h %h", $time,
						exp_r.vx, exp_r.vy, exp_r.vz, got.vx, got.vy, got.vz);
				end
				if (got.pitch !== exp_r.pitch) begin
					errors++;
					$display("%0t: pitch exp %h got %h", $time, exp_r.pitch, got.pitch);
				end
				if (got.yaw !== exp_r.yaw) begin
					errors++;
					$display("%0t: yaw exp %h got %h", $time, exp_r.yaw, got.yaw);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (n_res != n_res_seen) begin
				n_res_seen <= n_res;
				if ($urandom_range(0, 15) == 0)
					m_quiet = ~m_quiet;
				m_wait = m_quiet ? 0 : $urandom_range(0, 4);
			end
			if (m_wait > 0) begin
				m_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_req(logic act, logic [15:0] idx, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		item_t it;
		it.action = act;
		it.idx = idx;
		it.px = x; it.py = y; it.pz = z;
		it.nx = nx; it.ny = ny; it.nz = nz;
		pending_q.insert(pending_q.size(), it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_STANDOFF: standoff = longint'(val[20:0]);
			REG_EXT_X: ext[0] = longint'(val[30:0]);
			REG_EXT_Y: ext[1] = longint'(val[30:0]);
			REG_EXT_Z: ext[2] = longint'(val[30:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && n_sent == n_acc && expected_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// anchor with a normal drawn from one of several shapes, then tests, most around it
	task automatic random_burst(int n_tests);
		logic [31:0] ax, ay, az;
		logic [15:0] nx, ny, nz;
		int off;
		ax = $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 1 << 24)) -
			(1 << 23));
		ay = $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 1 << 24)) -
			(1 << 23));
		az = $urandom;
		case ($urandom_range(0, 4))
			0: begin nx = 16'($urandom); ny = 16'($urandom); nz = 16'($urandom); end
			1: begin
				nx = 16'($urandom_range(0, 64) - 32);
				ny = 16'($urandom_range(0, 64) - 32);
				nz = 16'($urandom_range(0, 64) - 32);
			end
			2: begin nx = '0; ny = 16'($urandom); nz = '0; end
			3: begin
				nx = 16'($urandom); ny = '0;
				nz = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			end
			default: begin
				nx = 16'($urandom_range(0, 32768) - 16384);
				ny = 16'($urandom_range(0, 32768) - 16384);
				nz = 16'($urandom_range(0, 32768) - 16384);
			end
		endcase
		add_req(ACT_ANCHOR, 16'($urandom), ax, ay, az, nx, ny, nz);
		for (int i = 0; i < n_tests; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				off = $urandom_range(0, 6 * 65536);
				add_req(ACT_TEST, 16'($urandom),
					32'(ax + 32'($urandom_range(0, 6 * 65536)) - 3 * 65536),
					32'(ay + 32'($urandom_range(0, 6 * 65536)) - 3 * 65536),
					32'(az + 32'(off) - 3 * 65536),
					16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				add_req(ACT_TEST, 16'($urandom), $urandom, $urandom, $urandom,
					16'($urandom), 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		standoff = STANDOFF_RST;
		ext[0] = EXT_X_RST;
		ext[1] = EXT_Y_RST;
		ext[2] = EXT_Z_RST;
		vpos = '{0, 0, 0};
		vrot = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset viewpoint, zero and vertical normals, extremes, saturation
		add_req(ACT_TEST, 16'h0000, 32'h0001_0000, 32'h0000_8000, 32'hffff_0000, '0, '0, '0);
		add_req(ACT_TEST, 16'hffff, 32'h0002_0000, 32'h0001_8000, 32'h0001_8000, '0, '0, '0);
		add_req(ACT_TEST, 16'h1234, 32'h0002_0001, '0, '0, '0, '0, '0);
		add_req(ACT_ANCHOR, 16'hffff, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
			'0, '0, '0);
		add_req(ACT_TEST, 16'h0001, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
			'0, '0, '0);
		add_req(ACT_ANCHOR, 16'h0002, '0, '0, '0, '0, 16'sd16384, '0);
		add_req(ACT_TEST, 16'h0003, '0, 32'hffff_0000, '0, '0, '0, '0);
		add_req(ACT_ANCHOR, 16'h0004, '0, '0, '0, '0, 16'h8000, '0);
		add_req(ACT_ANCHOR, 16'h0005, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			16'h8000, 16'h8000, 16'h8000);
		add_req(ACT_TEST, 16'h0006, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			16'hffff, 16'hffff, 16'hffff);
		add_req(ACT_ANCHOR, 16'h0007, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			16'h7fff, 16'h7fff, 16'h7fff);
		add_req(ACT_TEST, 16'h0008, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			'0, '0, '0);
		add_req(ACT_ANCHOR, 16'h0009, '0, '0, '0, 16'h8000, '0, '0);
		add_req(ACT_ANCHOR, 16'h000a, '0, '0, '0, '0, '0, 16'h8000);
		add_req(ACT_ANCHOR, 16'h000b, '0, '0, '0, 16'h0001, 16'hffff, 16'h0001);
		add_req(ACT_TEST, 16'h000c, 32'h0000_1000, 32'hfff0_0000, 32'h0001_0000,
			'0, '0, '0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: ;
				1: begin
					write_reg(REG_STANDOFF, 32'd1048576);
					write_reg(REG_EXT_X, 32'h7fff_ffff);
					write_reg(REG_EXT_Y, 32'h7fff_ffff);
					write_reg(REG_EXT_Z, 32'h7fff_ffff);
				end
				2: begin
					write_reg(REG_STANDOFF, 32'd0);
					write_reg(REG_EXT_X, 32'd0);
					write_reg(REG_EXT_Y, 32'd0);
					write_reg(REG_EXT_Z, 32'd0);
					add_req(ACT_ANCHOR, 16'h0100, 32'h0001_0000, 32'h0002_0000,
						32'h0003_0000, 16'h1000, 16'h2000, 16'h0800);
					add_req(ACT_TEST, 16'h0101, 32'h0001_0000, 32'h0002_0000,
						32'h0003_0000, '0, '0, '0);
				end
				3: begin
					write_reg(REG_STANDOFF, 32'hffff_ffff);
					write_reg(REG_EXT_X, 32'hffff_ffff);
					write_reg(REG_NONE, 32'h0000_0001);
					write_reg(REG_EXT_X, 32'($urandom_range(0, 4 << 16)));
					write_reg(REG_EXT_Y, 32'($urandom_range(0, 4 << 16)));
					write_reg(REG_EXT_Z, 32'($urandom_range(0, 4 << 16)));
				end
				default: begin
					write_reg(REG_STANDOFF, 32'($urandom_range(0, 1048576)));
					write_reg(REG_EXT_X, $urandom);
					write_reg(REG_EXT_Y, 32'($urandom_range(0, 3 << 16)));
					write_reg(REG_EXT_Z, 32'($urandom_range(0, 3 << 16)));
				end
			endcase
			for (int b = 0; b < 10; b++)
				random_burst($urandom_range(4, 14));
			drain();
		end

		$display("checked %0d viewpoint results and %0d point tests (%0d in the box)",
			n_anchor, n_test, n_hit);
		$display("register settings covered defaults, maximum, zero and random values");
		if (errors == 0 && expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/vbc_pkg.sv
rtl/vbc_front.sv
rtl/vbc_back.sv
rtl/viewpoint_box_cull.sv
bench/tb.sv
